[src/record_median_filter_assert.svh]
// Assertion macros for record_median_filter
`ifndef RECORD_MEDIAN_FILTER_ASSERT_SVH
`define RECORD_MEDIAN_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define RMF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("record_median_filter assertion failed");
`define RMF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("record_median_filter assertion failed");
`else
`define RMF_ASSERT_IMP(lbl, ante, cons)
`define RMF_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[src/rmf_pkg.sv]
package rmf_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_HALF    = 7;
    localparam int HALF_BITS   = 3;
    localparam logic [HALF_BITS-1:0] HALF_RESET = 3'd1;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } src_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] median;
        logic                          last_res;
    } res_t;

    // per-job control that rides with the window through the queue
    typedef struct packed {
        logic [HALF_BITS-1:0] half;
        logic                 last;
    } job_ctl_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_RANK,
        B_HOLD
    } back_state_t;

endpackage

[src/rmf_front.sv]
module rmf_front #(
    parameter int MAX_HALF = rmf_pkg::MAX_HALF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic [rmf_pkg::HALF_BITS-1:0]                  half_width,
    input  logic                                           src_valid,
    output logic                                           src_stall,
    input  rmf_pkg::src_t                                  src_data,
    output logic                                           job_push,
    input  logic                                           job_full,
    output rmf_pkg::job_ctl_t                              job_ctl,
    output logic [2*MAX_HALF:0][rmf_pkg::SAMPLE_BITS-1:0]  job_win
);

    localparam int WIN = 2 * MAX_HALF + 1;
    localparam int CW  = $clog2(WIN + 1);
    localparam int KW  = $clog2(2 * WIN);
    localparam int AW  = $clog2(WIN);
    localparam int HIW = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
    localparam int SB  = rmf_pkg::SAMPLE_BITS;

    logic [SB-1:0]                  recent_reg [WIN];
    logic [SB-1:0]                  head_reg [MAX_HALF];
    logic [CW-1:0]                  seen_reg;
    logic [CW-1:0]                  n_reg;
    logic [rmf_pkg::HALF_BITS-1:0]  h_reg;
    logic [KW-1:0]                  i_reg;
    logic [KW-1:0]                  iend_reg;
    logic                           pass_reg;
    logic                           last_reg;
    logic                           busy_reg;

    logic                           accept;
    logic [rmf_pkg::HALF_BITS-1:0]  h_eff;
    logic [CW-1:0]                  n_new;
    logic [KW-1:0]                  first_i;

    assign accept    = src_valid && !busy_reg;
    assign src_stall = busy_reg;
    assign h_eff     = (int'(half_width) > MAX_HALF) ?
                       rmf_pkg::HALF_BITS'(MAX_HALF) : half_width;
    assign n_new     = (seen_reg == CW'(WIN)) ? seen_reg : seen_reg + CW'(1);
    assign first_i   = KW'(n_new) - KW'(1) - KW'(h_eff);

    assign job_push     = busy_reg && !job_full;
    assign job_ctl.half = pass_reg ? '0 : h_reg;
    assign job_ctl.last = last_reg && (i_reg == iend_reg);

    // resolve the padded window for job i_reg, one lane per entry
    always_comb
    begin
        logic [KW-1:0] k;
        logic [KW-1:0] m;
        logic [KW-1:0] age;
        logic [KW-1:0] kh;
        logic [KW-1:0] nk;
        kh = KW'(h_reg);
        nk = KW'(n_reg);
        for (int a = 0; a < WIN; a++)
        begin
            k = i_reg + KW'(a);
            m = '0;
            if (pass_reg)
            begin
                age = nk - KW'(1) - i_reg;
            end
            else if (k >= kh)
            begin
                m   = (k < nk + kh) ? k - kh : k - (kh << 1);
                age = nk - KW'(1) - m;
            end
            else
            begin
                age = '0;
            end
            if (!pass_reg && k < kh)
                job_win[a] = head_reg[k[HIW-1:0]];
            else if (age < KW'(WIN))
                job_win[a] = recent_reg[age[AW-1:0]];
            else
                job_win[a] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg <= '0;
            busy_reg <= 1'b0;
        end
        else if (accept)
        begin
            seen_reg <= src_data.last ? '0 : n_new;
            if (KW'(n_new) <= KW'(h_eff))
                busy_reg <= src_data.last;
            else
                busy_reg <= 1'b1;
        end
        else if (job_push && i_reg == iend_reg)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            recent_reg[0] <= src_data.sample;
            for (int k = 1; k < WIN; k++)
                recent_reg[k] <= recent_reg[k-1];
            if (seen_reg < CW'(MAX_HALF))
                head_reg[seen_reg[HIW-1:0]] <= src_data.sample;
            n_reg    <= n_new;
            h_reg    <= h_eff;
            last_reg <= src_data.last;
            if (KW'(n_new) <= KW'(h_eff))
            begin
                pass_reg <= 1'b1;
                i_reg    <= '0;
                iend_reg <= KW'(n_new) - KW'(1);
            end
            else
            begin
                pass_reg <= 1'b0;
                i_reg    <= first_i;
                iend_reg <= src_data.last ? KW'(n_new) - KW'(1) : first_i;
            end
        end
        else if (job_push)
        begin
            i_reg <= i_reg + KW'(1);
        end
    end

endmodule

[src/rmf_queue.sv]
module rmf_queue #(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

endmodule

[src/rmf_back.sv]
module rmf_back #(
    parameter int MAX_HALF = rmf_pkg::MAX_HALF
) (
    input  logic                                           clk,
    input  logic                                           rst_n,
    input  logic                                           job_valid,
    output logic                                           job_pop,
    input  rmf_pkg::job_ctl_t                              job_ctl,
    input  logic [2*MAX_HALF:0][rmf_pkg::SAMPLE_BITS-1:0]  job_win,
    output logic                                           res_valid,
    input  logic                                           res_stall,
    output rmf_pkg::res_t                                  res_data
);

    localparam int WIN = 2 * MAX_HALF + 1;
    localparam int CW  = $clog2(WIN + 1);
    localparam int AW  = $clog2(WIN);
    localparam int SB  = rmf_pkg::SAMPLE_BITS;

    rmf_pkg::back_state_t             state_reg, state_next;
    logic [WIN-1:0][SB-1:0]           win_reg;
    logic [rmf_pkg::HALF_BITS-1:0]    h_reg;
    logic                             last_reg;
    logic [AW-1:0]                    j_reg, j_next;
    logic [SB-1:0]                    med_reg, med_next;

    logic [SB-1:0]  cand;
    logic [WIN-1:0] lt_vec;
    logic [WIN-1:0] le_vec;
    logic [CW-1:0]  lt_cnt;
    logic [CW-1:0]  le_cnt;
    logic           hit;

    // rank of the current candidate against the live part of the window
    always_comb
    begin
        cand = win_reg[j_reg];
        for (int a = 0; a < WIN; a++)
        begin
            lt_vec[a] = (a <= 2 * int'(h_reg)) &&
                        ($signed(win_reg[a]) < $signed(cand));
            le_vec[a] = (a <= 2 * int'(h_reg)) &&
                        ($signed(win_reg[a]) <= $signed(cand));
        end
        lt_cnt = CW'($countones(lt_vec));
        le_cnt = CW'($countones(le_vec));
        hit    = (lt_cnt <= CW'(h_reg)) && (le_cnt > CW'(h_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        j_next     = j_reg;
        med_next   = med_reg;
        job_pop    = 1'b0;
        res_valid  = 1'b0;
        unique case (state_reg)
            rmf_pkg::B_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    j_next     = '0;
                    state_next = rmf_pkg::B_RANK;
                end
            end
            rmf_pkg::B_RANK:
            begin
                if (hit)
                begin
                    med_next   = cand;
                    state_next = rmf_pkg::B_HOLD;
                end
                else
                begin
                    j_next = j_reg + AW'(1);
                end
            end
            rmf_pkg::B_HOLD:
            begin
                res_valid = 1'b1;
                if (!res_stall)
                    state_next = rmf_pkg::B_IDLE;
            end
            default:
            begin
                state_next = rmf_pkg::B_IDLE;
            end
        endcase
    end

    assign res_data.median   = med_reg;
    assign res_data.last_res = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rmf_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        j_reg   <= j_next;
        med_reg <= med_next;
        if (job_pop)
        begin
            win_reg  <= job_win;
            h_reg    <= job_ctl.half;
            last_reg <= job_ctl.last;
        end
    end

endmodule

[src/record_median_filter.sv]
// Sliding-window median over a record of signed samples, window 2h+1 with h
// from the half_width register (reset 1). The front end takes one sample per
// transaction and turns it into zero or more median jobs, pushed one per
// cycle while the two-entry job queue is not full; it stalls the source
// until all jobs of the sample are queued, so at the end of a record it
// holds for up to h+1 jobs. The back end ranks one candidate per cycle
// against the whole window until it finds the median, holds it in the output
// register until it is taken and takes no new job meanwhile. A record of
// n <= h samples is passed through unchanged at its last sample.
module record_median_filter #(
    parameter int MAX_HALF = rmf_pkg::MAX_HALF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [rmf_pkg::HALF_BITS-1:0] cfg_wr_data,
    input  logic                          src_valid,
    output logic                          src_stall,
    input  rmf_pkg::src_t                 src_data,
    output logic                          res_valid,
    input  logic                          res_stall,
    output rmf_pkg::res_t                 res_data
);

    `include "record_median_filter_assert.svh"

    localparam int WIN   = 2 * MAX_HALF + 1;
    localparam int SB    = rmf_pkg::SAMPLE_BITS;
    localparam int CTLW  = $bits(rmf_pkg::job_ctl_t);
    localparam int JOBW  = WIN * SB + CTLW;

    logic [rmf_pkg::HALF_BITS-1:0] half_width_reg;

    logic                    push;
    logic                    q_full;
    logic                    pop;
    logic                    q_valid;
    rmf_pkg::job_ctl_t       push_ctl;
    logic [WIN-1:0][SB-1:0]  push_win;
    logic [JOBW-1:0]         q_out;
    rmf_pkg::job_ctl_t       pop_ctl;
    logic [WIN-1:0][SB-1:0]  pop_win;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            half_width_reg <= rmf_pkg::HALF_RESET;
        else if (cfg_wr_en)
            half_width_reg <= cfg_wr_data;
    end

    rmf_front #(.MAX_HALF(MAX_HALF)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .half_width (half_width_reg),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_data   (src_data),
        .job_push   (push),
        .job_full   (q_full),
        .job_ctl    (push_ctl),
        .job_win    (push_win)
    );

    rmf_queue #(.WIDTH(JOBW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_ctl, push_win}),
        .full      (q_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    assign pop_ctl = q_out[JOBW-1 -: CTLW];
    assign pop_win = q_out[WIN*SB-1:0];

    rmf_back #(.MAX_HALF(MAX_HALF)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_pop   (pop),
        .job_ctl   (pop_ctl),
        .job_win   (pop_win),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    `RMF_ASSERT_IMP(a_full_not_empty, q_full, q_valid)
    `RMF_ASSERT_IMP(a_no_push_full, push, !q_full)
    `RMF_ASSERT_IMP(a_no_pop_holding, res_valid, !pop)
    `RMF_ASSERT_NXT(a_pop_no_result, pop, !res_valid)

endmodule

[test/record_median_filter_tb.sv]
`timescale 1ns / 100ps

module record_median_filter_tb;

    localparam int WIN_LEN = 2 * rmf_pkg::MAX_HALF + 1;
    localparam int SBITS   = rmf_pkg::SAMPLE_BITS;

    class median_scoreboard;
        logic signed [SBITS-1:0] first_vals[rmf_pkg::MAX_HALF];
        logic signed [SBITS-1:0] newest_vals[WIN_LEN];
        int unsigned             record_len;
        int unsigned             half;
        rmf_pkg::res_t           expected_q[$];
        int                      errors;

        function void clear();
            foreach (first_vals[k]) first_vals[k] = '0;
            foreach (newest_vals[k]) newest_vals[k] = '0;
            record_len = 0;
            half = rmf_pkg::HALF_RESET;
            errors = 0;
        endfunction

        function logic signed [SBITS-1:0] aged(int unsigned age);
            if (age >= WIN_LEN)
                return '0;
            return newest_vals[age];
        endfunction

        // entry k of the record extended with h head samples and h tail samples
        function logic signed [SBITS-1:0] extended(int unsigned k, int unsigned n,
                                                   int unsigned h);
            int unsigned m;
            if (k < h)
                return (k < rmf_pkg::MAX_HALF) ? first_vals[k] : '0;
            m = (k < n + h) ? k - h : k - 2 * h;
            if (m >= n)
                return '0;
            return aged(n - 1 - m);
        endfunction

        function logic signed [SBITS-1:0] median_at(int unsigned i, int unsigned n,
                                                    int unsigned h);
            logic signed [SBITS-1:0] win[WIN_LEN];
            logic signed [SBITS-1:0] v;
            int unsigned             b;
            for (int unsigned a = 0; a < 2 * h + 1; a++)
            begin
                v = extended(i + a, n, h);
                b = a;
                while (b > 0 && win[b-1] > v)
                begin
                    win[b] = win[b-1];
                    b--;
                end
                win[b] = v;
            end
            return win[h];
        endfunction

        function void note_input(rmf_pkg::src_t it);
            int unsigned   h;
            int unsigned   n;
            int unsigned   lo;
            int unsigned   hi;
            rmf_pkg::res_t r;
            h = (half > rmf_pkg::MAX_HALF) ? rmf_pkg::MAX_HALF : half;
            for (int k = WIN_LEN - 1; k > 0; k--)
                newest_vals[k] = newest_vals[k-1];
            newest_vals[0] = it.sample;
            if (record_len < rmf_pkg::MAX_HALF)
                first_vals[record_len] = it.sample;
            if (record_len < WIN_LEN)
                record_len++;
            n = record_len;
            if (n <= h)
            begin
                if (it.last)
                    for (int unsigned i = 0; i < n; i++)
                    begin
                        r.median = aged(n - 1 - i);
                        r.last_res = (i == n - 1);
                        expected_q.push_back(r);
                    end
            end
            else
            begin
                lo = n - 1 - h;
                hi = it.last ? n - 1 : lo;
                for (int unsigned i = lo; i <= hi; i++)
                begin
                    r.median = median_at(i, n, h);
                    r.last_res = it.last && (i == hi);
                    expected_q.push_back(r);
                end
            end
            if (it.last)
                record_len = 0;
        endfunction

        function void check_result(rmf_pkg::res_t got);
            rmf_pkg::res_t want;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result median=%0d last_res=%0b", $time,
                         got.median, got.last_res);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.median !== want.median)
            begin
                $display("%0t: median expected %0d actual %0d", $time, want.median,
                         got.median);
                errors++;
            end
            if (got.last_res !== want.last_res)
            begin
                $display("%0t: last_res expected %0b actual %0b", $time, want.last_res,
                         got.last_res);
                errors++;
            end
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_wr_en;
    logic [rmf_pkg::HALF_BITS-1:0] cfg_wr_data;
    logic                          src_valid;
    logic                          src_stall;
    rmf_pkg::src_t                 src_data;
    logic                          res_valid;
    logic                          res_stall;
    rmf_pkg::res_t                 res_data;

    median_scoreboard sb;
    int               hold_cycles;
    bit               bursty;
    int               burst_left;

    record_median_filter i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .src_valid   (src_valid),
        .src_stall   (src_stall),
        .src_data    (src_data),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res_data    (res_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("simulation failed");
        $finish;
    end

    // receiver: own stall pattern, plus a long hold-off on request
    initial
    begin
        int mode;
        int run;
        res_stall = 1'b0;
        mode = 0;
        run = 0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                hold_cycles--;
                res_stall <= 1'b1;
            end
            else
            begin
                if (run == 0)
                begin
                    mode = $urandom_range(0, 3);
                    run = $urandom_range(5, 60);
                end
                run--;
                case (mode)
                    0: res_stall <= 1'b0;
                    1: res_stall <= ($urandom_range(0, 3) == 0);
                    2: res_stall <= ($urandom_range(0, 1) == 0);
                    default: res_stall <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res_data);

    task automatic send_sample(logic signed [SBITS-1:0] s, logic lst);
        rmf_pkg::src_t it;
        it.sample = s;
        it.last = lst;
        if (bursty && burst_left == 0)
        begin
            src_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        src_valid <= 1'b1;
        src_data <= it;
        do @(posedge clk); while (src_stall);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        src_valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    task automatic write_half(int h);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= h[rmf_pkg::HALF_BITS-1:0];
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        sb.half = h;
    endtask

    function automatic logic signed [SBITS-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return SBITS'(int'($urandom_range(0, 7)) - 4);
            default: return SBITS'($urandom());
        endcase
    endfunction

    task automatic send_record(int len);
        for (int k = 0; k < len; k++)
            send_sample(pick_sample(), k == len - 1);
    endtask

    initial
    begin
        int sent;
        int len;
        int h;
        sb = new();
        sb.clear();
        hold_cycles = 0;
        bursty = 1'b0;
        burst_left = 0;
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        src_valid = 1'b0;
        src_data = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset width, extremes
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(-16'sd1, 1'b1);
        wait_drained();
        // pass-through width
        write_half(0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh7fff, 1'b1);
        wait_drained();
        // records no longer than h: passed through at the last sample
        write_half(3);
        send_sample(16'sh1234, 1'b0);
        send_sample(-16'sd5, 1'b1);
        send_sample(16'sh7fff, 1'b1);
        wait_drained();
        // width changed in the middle of a record
        write_half(1);
        send_sample(16'sd9, 1'b0);
        send_sample(-16'sd3, 1'b0);
        send_sample(16'sd40, 1'b0);
        send_sample(16'sh8000, 1'b0);
        wait_drained();
        write_half(3);
        send_sample(16'sd2, 1'b0);
        send_sample(16'sh7fff, 1'b0);
        send_sample(-16'sd7, 1'b1);
        wait_drained();
        // widest window over a record longer than the window
        write_half(7);
        for (int k = 0; k < 17; k++)
            send_sample(k[0] ? 16'sh8000 : SBITS'(32'sh7fff - k), k == 16);
        wait_drained();

        sent = 0;
        for (int phase = 0; sent < 400; phase++)
        begin
            h = (phase < 8) ? phase : $urandom_range(0, 7);
            write_half(h);
            bursty = (phase % 3) != 0;
            if (phase == 4)
            begin
                @(posedge clk);
                hold_cycles = 400;
                @(negedge clk);
            end
            for (int r = 0; r < 4; r++)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 30)
                                                  : $urandom_range(1, 12);
                send_record(len);
                sent += len;
            end
            wait_drained();
        end

        while (sb.expected_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+src
src/rmf_pkg.sv
src/rmf_front.sv
src/rmf_queue.sv
src/rmf_back.sv
src/record_median_filter.sv
test/record_median_filter_tb.sv
